[src/angle_zero_wrap_calibrate_average_macros.svh]
// Assertion macros for the relative angle averaging block.
// No dependencies; taken in by the top level through `include.
`ifndef ANGLE_ZERO_WRAP_CALIBRATE_AVERAGE_MACROS_SVH
`define ANGLE_ZERO_WRAP_CALIBRATE_AVERAGE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define AZWCA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define AZWCA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/azwca_pkg.sv]
// Shared constants for the relative angle averaging block: field widths,
// command codes, register indexes and reset values. No dependencies.
package azwca_pkg;

   localparam int unsigned RAW_W    = 12;
   localparam int unsigned GAIN_W   = 16;
   localparam int unsigned OFFSET_W = 22;
   localparam int unsigned ANGLE_W  = 24;
   localparam int unsigned CSR_W    = 22;
   localparam int unsigned CSR_IDX_W = 2;

   // wrapped count is -2048..2048, times 360 fits 21 signed bits
   localparam int unsigned DELTA_W  = 13;
   localparam int unsigned DEG_W    = 21;
   localparam int unsigned PROD_W   = DEG_W + GAIN_W;
   localparam int unsigned FRAC_W   = 12;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_REZERO = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_GAIN   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERT = 2'd2;

   localparam logic signed [GAIN_W-1:0] GAIN_RESET = 16'sd4096;

   localparam logic signed [13:0] HALF_TURN = 14'sd2048;
   localparam logic signed [13:0] FULL_TURN = 14'sd4096;
   localparam logic signed [DEG_W:0] DEG_PER_COUNT = 22'sd360;

endpackage

[src/angle_zero_wrap_calibrate_average.sv]
// Top level of the relative angle averaging block: zero reference, wrap,
// calibration and moving average over a ring memory. Uses azwca_pkg and
// the assertion macros header.
//
// Each beat on req_ carries a 12-bit raw sensor count and a command. A sample
// beat takes the count relative to the stored zero, wraps it onto the
// shortest path (-2048..2048 counts), optionally negates it, scales it to Q12
// degrees (x360), applies the Q12 gain with a floor shift and adds the
// offset. That value overwrites the oldest of FILTER_TAPS entries in the ring
// memory and the running total is corrected by the difference; the response
// carries floor(total / FILTER_TAPS). A rezero beat captures the raw count as
// the new zero, clears the ring and the total, and responds with 0. Every
// request beat gives exactly one response beat, raw count echoed.
// Throughput is one beat per cycle, sustained under any stall pattern that
// leaves the response side free; a request passes stages one to four into
// the response register. The ring is a single memory with one read
// and one write port; its read-modify-write spans stages two and three,
// and consecutive samples always touch different entries (two taps or more),
// so no forwarding is needed. Per-entry valid bits stand in for clearing, so
// there is no clearing pass after reset or rezero. The divide by FILTER_TAPS
// is a reciprocal multiply with a one-step correction (stages four and five).
// Configuration writes take effect at once and belong to idle periods only.
// FILTER_TAPS: 2 to 64.

`include "angle_zero_wrap_calibrate_average_macros.svh"

module angle_zero_wrap_calibrate_average #(
   parameter int unsigned FILTER_TAPS = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // configuration write port
   input  logic                                   csr_we,
   input  logic [azwca_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [azwca_pkg::CSR_W-1:0]            csr_wdata,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_cmd,
   input  logic [azwca_pkg::RAW_W-1:0]            req_raw_angle,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [azwca_pkg::ANGLE_W-1:0]   rsp_filtered_angle,
   output logic [azwca_pkg::RAW_W-1:0]            rsp_raw_echo
);

   // ring index width and running total width follow from the tap count
   localparam int unsigned POS_W = $clog2(FILTER_TAPS);
   localparam int unsigned TOT_W = azwca_pkg::ANGLE_W + $clog2(FILTER_TAPS);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(FILTER_TAPS - 1);
   localparam logic [TOT_W-1:0] TAPS_T = TOT_W'(FILTER_TAPS);
   // floor(2^TOT_W / taps): quotient estimate is exact or one short
   localparam logic [TOT_W-1:0] RECIP = TOT_W'((64'd1 << TOT_W) / FILTER_TAPS);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic signed [azwca_pkg::GAIN_W-1:0]   gain_ff;
   logic signed [azwca_pkg::OFFSET_W-1:0] offset_ff;
   logic                                  invert_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= azwca_pkg::GAIN_RESET;
         offset_ff <= '0;
         invert_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            azwca_pkg::CSR_GAIN:   gain_ff   <= csr_wdata[azwca_pkg::GAIN_W-1:0];
            azwca_pkg::CSR_OFFSET: offset_ff <= csr_wdata[azwca_pkg::OFFSET_W-1:0];
            azwca_pkg::CSR_INVERT: invert_ff <= csr_wdata[0];
            default: ;  // unused index: drop the write
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Stage occupancy and flow control: a stage loads when it is empty or
   // when its content moves on, so bubbles collapse under stall.
   // ---------------------------------------------------------------------
   logic v1_ff, v2_ff, v3_ff, v4_ff, rsp_valid_ff;
   logic ld1, ld2, ld3, ld4, ld_out;
   logic req_accept;

   assign ld_out = !rsp_valid_ff || !rsp_stall;
   assign ld4    = !v4_ff || ld_out;
   assign ld3    = !v3_ff || ld4;
   assign ld2    = !v2_ff || ld3;
   assign ld1    = !v1_ff || ld2;

   assign req_stall  = !ld1;
   assign req_accept = req_valid && ld1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ld1)    v1_ff        <= req_valid;
         if (ld2)    v2_ff        <= v1_ff;
         if (ld3)    v3_ff        <= v2_ff;
         if (ld4)    v4_ff        <= v3_ff;
         if (ld_out) rsp_valid_ff <= v4_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1 entry: relative count, shortest-path wrap, direction, x360
   // ---------------------------------------------------------------------
   logic [azwca_pkg::RAW_W-1:0] zero_ff, zero_in;
   logic [POS_W-1:0]            pos_ff, pos_in;
   logic signed [13:0]          diff_w, wrap_w, dir_w;
   logic signed [azwca_pkg::DELTA_W-1:0] delta_w;
   logic signed [azwca_pkg::DEG_W:0]     deg_w;

   always_comb begin
      diff_w = $signed({2'b00, req_raw_angle}) - $signed({2'b00, zero_ff});
      if (diff_w > azwca_pkg::HALF_TURN) begin
         wrap_w = diff_w - azwca_pkg::FULL_TURN;
      end else if (diff_w < -azwca_pkg::HALF_TURN) begin
         wrap_w = diff_w + azwca_pkg::FULL_TURN;
      end else begin
         wrap_w = diff_w;
      end
      dir_w   = invert_ff ? -wrap_w : wrap_w;
      delta_w = dir_w[azwca_pkg::DELTA_W-1:0];
      deg_w   = $signed({{(azwca_pkg::DEG_W + 1 - azwca_pkg::DELTA_W){delta_w[12]}}, delta_w})
                * azwca_pkg::DEG_PER_COUNT;
   end

   // zero moves on rezero at once; ring position advances on samples only
   always_comb begin
      zero_in = zero_ff;
      pos_in  = pos_ff;
      if (req_accept) begin
         if (req_cmd == azwca_pkg::CMD_REZERO) begin
            zero_in = req_raw_angle;
         end else begin
            pos_in = (pos_ff == POS_LAST) ? '0 : pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_ff <= '0;
         pos_ff  <= '0;
      end else begin
         zero_ff <= zero_in;
         pos_ff  <= pos_in;
      end
   end

   logic                                  cmd1_ff;
   logic [azwca_pkg::RAW_W-1:0]           raw1_ff;
   logic signed [azwca_pkg::DEG_W-1:0]    deg1_ff;
   logic [POS_W-1:0]                      pos1_ff;

   always_ff @(posedge clock) begin
      if (ld1) begin
         cmd1_ff <= req_cmd;
         raw1_ff <= req_raw_angle;
         deg1_ff <= deg_w[azwca_pkg::DEG_W-1:0];
         pos1_ff <= pos_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: gain multiply, ring read
   // ---------------------------------------------------------------------
   logic signed [azwca_pkg::ANGLE_W-1:0] ring_mem [FILTER_TAPS];
   logic [FILTER_TAPS-1:0]               ring_vld_ff;
   logic                                 ring_wr, ring_clr;

   logic                                 cmd2_ff;
   logic [azwca_pkg::RAW_W-1:0]          raw2_ff;
   logic signed [azwca_pkg::PROD_W-1:0]  prod2_ff;
   logic [POS_W-1:0]                     pos2_ff;
   logic signed [azwca_pkg::ANGLE_W-1:0] old2_ff;
   logic                                 old_vld2_ff;

   always_ff @(posedge clock) begin
      if (ld2) begin
         cmd2_ff     <= cmd1_ff;
         raw2_ff     <= raw1_ff;
         prod2_ff    <= azwca_pkg::PROD_W'(deg1_ff) * azwca_pkg::PROD_W'(gain_ff);
         pos2_ff     <= pos1_ff;
         old2_ff     <= ring_mem[pos1_ff];
         // a rezero leaving stage 2 on this edge empties the entry
         old_vld2_ff <= ring_vld_ff[pos1_ff] && !ring_clr;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3 entry: calibrate, replace the oldest entry, correct the total
   // ---------------------------------------------------------------------
   logic signed [azwca_pkg::ANGLE_W-1:0] cal_w, old_w;
   logic signed [TOT_W-1:0]              total_ff, total_in;

   assign ring_wr  = v2_ff && ld3 && (cmd2_ff == azwca_pkg::CMD_SAMPLE);
   assign ring_clr = v2_ff && ld3 && (cmd2_ff == azwca_pkg::CMD_REZERO);

   always_comb begin
      // floor shift by the gain's fraction bits; the sum always fits 24 bits
      cal_w = prod2_ff[azwca_pkg::FRAC_W + azwca_pkg::ANGLE_W - 1:azwca_pkg::FRAC_W]
              + azwca_pkg::ANGLE_W'(offset_ff);
      old_w = old_vld2_ff ? old2_ff : '0;
      if (ring_clr) begin
         total_in = '0;
      end else if (ring_wr) begin
         total_in = total_ff - TOT_W'(old_w) + TOT_W'(cal_w);
      end else begin
         total_in = total_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ring_wr) begin
         ring_mem[pos2_ff] <= cal_w;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_vld_ff <= '0;
         total_ff    <= '0;
      end else begin
         total_ff <= total_in;
         if (ring_clr) begin
            ring_vld_ff <= '0;
         end else if (ring_wr) begin
            ring_vld_ff[pos2_ff] <= 1'b1;
         end
      end
   end

   logic [azwca_pkg::RAW_W-1:0] raw3_ff;
   logic signed [TOT_W-1:0]     tot3_ff;

   always_ff @(posedge clock) begin
      if (ld3) begin
         raw3_ff <= raw2_ff;
         tot3_ff <= total_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 4: floor divide by the tap count, part one. Negative totals go
   // through the magnitude rounded up: floor(t/n) = -floor((n-1-t)/n).
   // ---------------------------------------------------------------------
   logic [TOT_W-1:0]            mag_w;
   logic [azwca_pkg::RAW_W-1:0] raw4_ff;
   logic                        neg4_ff;
   logic [TOT_W-1:0]            mag4_ff;
   logic [2*TOT_W-1:0]          prod4_ff;

   assign mag_w = tot3_ff[TOT_W-1] ? (~tot3_ff) + TAPS_T : tot3_ff;

   always_ff @(posedge clock) begin
      if (ld4) begin
         raw4_ff  <= raw3_ff;
         neg4_ff  <= tot3_ff[TOT_W-1];
         mag4_ff  <= mag_w;
         prod4_ff <= (2*TOT_W)'(mag_w) * (2*TOT_W)'(RECIP);
      end
   end

   // ---------------------------------------------------------------------
   // Stage 5 entry: correct the quotient estimate, restore the sign
   // ---------------------------------------------------------------------
   logic [TOT_W-1:0]                     quo_est_w, rem_w, quo_w;
   logic signed [azwca_pkg::ANGLE_W-1:0] avg_w;

   always_comb begin
      quo_est_w = prod4_ff[2*TOT_W-1:TOT_W];
      rem_w     = mag4_ff - TOT_W'(quo_est_w * TAPS_T);
      quo_w     = (rem_w >= TAPS_T) ? quo_est_w + TOT_W'(1) : quo_est_w;
      avg_w     = neg4_ff ? -quo_w[azwca_pkg::ANGLE_W-1:0] : quo_w[azwca_pkg::ANGLE_W-1:0];
   end

   logic signed [azwca_pkg::ANGLE_W-1:0] rsp_angle_ff;
   logic [azwca_pkg::RAW_W-1:0]          rsp_raw_ff;

   // hold the response beat while the far side stalls
   always_ff @(posedge clock) begin
      if (ld_out) begin
         rsp_angle_ff <= avg_w;
         rsp_raw_ff   <= raw4_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_filtered_angle = rsp_angle_ff;
   assign rsp_raw_echo       = rsp_raw_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `AZWCA_ASSERT_NEXT(a_rezero_clears_total, clock, reset, ring_clr, total_ff == '0,
      "running total not cleared by rezero")
   `AZWCA_ASSERT_NEXT(a_rezero_clears_ring, clock, reset, ring_clr, ring_vld_ff == '0,
      "ring entries still valid after rezero")
   `AZWCA_ASSERT_NOW(a_stall_only_when_full, clock, reset, req_stall,
      v1_ff && v2_ff && v3_ff && v4_ff && rsp_valid_ff,
      "request stalled with a free stage")
   `AZWCA_ASSERT_NEXT(a_pos_holds_without_sample, clock, reset,
      !(req_accept && (req_cmd == azwca_pkg::CMD_SAMPLE)), $stable(pos_ff),
      "ring position moved without a sample beat")

endmodule

[tb/angle_average_checker.sv]
// Checker for the relative angle averaging block: watches the csr, req and rsp
// ports, predicts every rsp beat and compares it field by field.
// Depends on azwca_pkg.
module angle_average_checker
   import azwca_pkg::*;
#(
   parameter int unsigned TAPS = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_W-1:0]           csr_wdata,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic                       req_cmd,
   input  logic [RAW_W-1:0]           req_raw_angle,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic signed [ANGLE_W-1:0]  rsp_filtered_angle,
   input  logic [RAW_W-1:0]           rsp_raw_echo,
   output int                         outstanding,
   output int                         fault_count
);

   localparam longint TAP_COUNT = TAPS;

   typedef struct packed {
      logic [ANGLE_W-1:0] angle;
      logic [RAW_W-1:0]   raw;
   } angle_beat_type;

   angle_beat_type awaited_angles[$];
   int             mismatches = 0;

   // calibration settings and filter state as the block should hold them
   longint              gain_cfg;
   longint              offset_cfg;
   logic                invert_cfg;
   logic [RAW_W-1:0]    zero_ref;
   longint              ring_vals[TAPS];
   int unsigned         ring_pos;
   longint              ring_sum;

   assign fault_count = mismatches;

   task automatic report_mismatch(string what, logic [ANGLE_W-1:0] want,
                                  logic [ANGLE_W-1:0] got);
      $display("mismatch on %s: expected %h, got %h at %0t", what, want, got, $time);
      mismatches++;
   endtask

   function automatic angle_beat_type next_average(logic cmd, logic [RAW_W-1:0] raw);
      angle_beat_type beat;
      longint         rel;
      longint         cal;
      longint         quot;
      beat.raw = raw;
      if (cmd == CMD_REZERO) begin
         zero_ref = raw;
         foreach (ring_vals[i]) ring_vals[i] = 0;
         ring_sum   = 0;
         beat.angle = '0;
      end else begin
         rel = longint'(raw) - longint'(zero_ref);
         // shortest path, both half turns kept as they are
         if (rel > 2048) rel -= 4096;
         if (rel < -2048) rel += 4096;
         if (invert_cfg) rel = -rel;
         cal = ((rel * 360 * gain_cfg) >>> FRAC_W) + offset_cfg;
         ring_sum = ring_sum - ring_vals[ring_pos] + cal;
         ring_vals[ring_pos] = cal;
         ring_pos = (ring_pos + 1) % TAPS;
         quot = ring_sum / TAP_COUNT;
         if ((ring_sum % TAP_COUNT) != 0 && ring_sum < 0) quot -= 1;
         beat.angle = ANGLE_W'(quot);
      end
      return beat;
   endfunction

   always @(posedge clock) begin
      angle_beat_type want;
      if (reset) begin
         gain_cfg   = longint'(GAIN_RESET);
         offset_cfg = 0;
         invert_cfg = 1'b0;
         zero_ref   = '0;
         foreach (ring_vals[i]) ring_vals[i] = 0;
         ring_pos   = 0;
         ring_sum   = 0;
         awaited_angles.delete();
         outstanding <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_GAIN:   gain_cfg   = longint'($signed(csr_wdata[GAIN_W-1:0]));
               CSR_OFFSET: offset_cfg = longint'($signed(csr_wdata[OFFSET_W-1:0]));
               CSR_INVERT: invert_cfg = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            awaited_angles.push_back(next_average(req_cmd, req_raw_angle));
         if (rsp_valid && !rsp_stall) begin
            if (awaited_angles.size() == 0) begin
               report_mismatch("unexpected beat", '0, rsp_filtered_angle);
            end else begin
               want = awaited_angles.pop_front();
               if (rsp_filtered_angle !== want.angle)
                  report_mismatch("filtered_angle", want.angle, rsp_filtered_angle);
               if (rsp_raw_echo !== want.raw)
                  report_mismatch("raw_echo", ANGLE_W'(want.raw), ANGLE_W'(rsp_raw_echo));
            end
         end
         outstanding <= awaited_angles.size();
      end
   end

endmodule

[tb/testbench.sv]
// Top of the testbench for the relative angle averaging block: clock, reset,
// stimulus, stall patterns and the verdict. Depends on azwca_pkg, the block
// and angle_average_checker.
module testbench;
   import azwca_pkg::*;

   localparam int unsigned TAPS            = 8;
   localparam int unsigned ITEMS_PER_PHASE = 207;
   localparam int unsigned PHASES          = 7;
   localparam int unsigned HOLD_CYCLES     = 64;
   localparam int unsigned WATCHDOG_LIMIT  = 2000;
   // index with no register behind it; writes there must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   // Opening beats under reset settings: zero and all-ones counts, both half
   // turns kept, wrap from above and below, alternating bit patterns, a ring
   // that wraps round, and back-to-back rezeros.
   localparam logic [RAW_W:0] OPENING[24] = '{
      {CMD_SAMPLE, 12'd0},    {CMD_SAMPLE, 12'd4095}, {CMD_SAMPLE, 12'd2048},
      {CMD_SAMPLE, 12'd2049}, {CMD_SAMPLE, 12'd1},    {CMD_SAMPLE, 12'hAAA},
      {CMD_SAMPLE, 12'h555},  {CMD_SAMPLE, 12'd4095}, {CMD_SAMPLE, 12'd2047},
      {CMD_REZERO, 12'd2048}, {CMD_SAMPLE, 12'd0},    {CMD_SAMPLE, 12'd4095},
      {CMD_SAMPLE, 12'd2048}, {CMD_REZERO, 12'd4095}, {CMD_REZERO, 12'd4095},
      {CMD_SAMPLE, 12'd0},    {CMD_SAMPLE, 12'd2046}, {CMD_SAMPLE, 12'd2047},
      {CMD_SAMPLE, 12'd2048}, {CMD_REZERO, 12'd0},    {CMD_SAMPLE, 12'd2048},
      {CMD_SAMPLE, 12'd2049}, {CMD_SAMPLE, 12'd4095}, {CMD_SAMPLE, 12'h7FF}
   };

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [CSR_W-1:0]           csr_wdata = '0;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic                       req_cmd = CMD_SAMPLE;
   logic [RAW_W-1:0]           req_raw_angle = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [ANGLE_W-1:0]  rsp_filtered_angle;
   logic [RAW_W-1:0]           rsp_raw_echo;

   int                         outstanding;
   int                         fault_count;

   // stall and gap rates, in percent
   int unsigned                tx_idle_pct = 0;
   int unsigned                rx_stall_pct = 0;
   // toggle to ask the receiver for one long hold-off
   logic                       hold_req = 1'b0;
   logic                       hold_ack = 1'b0;
   int unsigned                hold_left = 0;
   int unsigned                quiet_cycles = 0;
   // last zero captured; lets random counts land near the half turn
   logic [RAW_W-1:0]           zero_hint = '0;

   angle_zero_wrap_calibrate_average #(
      .FILTER_TAPS(TAPS)
   ) i_dut (
      .clock,
      .reset,
      .csr_we,
      .csr_index,
      .csr_wdata,
      .req_valid,
      .req_stall,
      .req_cmd,
      .req_raw_angle,
      .rsp_valid,
      .rsp_stall,
      .rsp_filtered_angle,
      .rsp_raw_echo
   );

   angle_average_checker #(
      .TAPS(TAPS)
   ) i_checker (
      .clock,
      .reset,
      .csr_we,
      .csr_index,
      .csr_wdata,
      .req_valid,
      .req_stall,
      .req_cmd,
      .req_raw_angle,
      .rsp_valid,
      .rsp_stall,
      .rsp_filtered_angle,
      .rsp_raw_echo,
      .outstanding,
      .fault_count
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: hold off for a long stretch when asked, otherwise stall at
   // the current rate.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_ack  <= 1'b0;
         hold_left <= 0;
      end else if (hold_req != hold_ack) begin
         hold_ack  <= hold_req;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_stall_pct);
      end
   end

   // Watchdog: count cycles in which no beat moves on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one beat after a random gap and hold it until it is taken.
   task automatic send_beat(logic cmd, logic [RAW_W-1:0] raw);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_cmd       <= cmd;
      req_raw_angle <= raw;
      if (cmd == CMD_REZERO) zero_hint = raw;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Drop valid and wait until every predicted beat has come back.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Write all registers, the spare index too; only while the block is idle.
   task automatic load_settings(logic [GAIN_W-1:0] gain, logic [OFFSET_W-1:0] offset,
                                logic invert);
      csr_we    <= 1'b1;
      csr_index <= CSR_GAIN;
      csr_wdata <= CSR_W'(gain);
      @(posedge clock);
      csr_index <= CSR_OFFSET;
      csr_wdata <= offset;
      @(posedge clock);
      csr_index <= CSR_INVERT;
      csr_wdata <= CSR_W'(invert);
      @(posedge clock);
      csr_index <= CSR_SPARE;
      csr_wdata <= CSR_W'($urandom);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      logic [GAIN_W-1:0]   gain;
      logic [OFFSET_W-1:0] offset;
      logic                invert;
      logic                with_hold;
      logic                cmd;
      logic [RAW_W-1:0]    raw;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (OPENING[i]) send_beat(OPENING[i][RAW_W], OPENING[i][RAW_W-1:0]);
      drain();

      for (int unsigned phase = 0; phase < PHASES; phase++) begin
         // settings of this phase: extremes first, then random ones, then the smallest positive gain
         with_hold = 1'b0;
         case (phase)
            0: begin
               gain = 16'h8000; offset = 22'h1FFFFF; invert = 1'b0;
               tx_idle_pct <= 0;  rx_stall_pct <= 0;  with_hold = 1'b1;
            end
            1: begin
               gain = 16'h7FFF; offset = 22'h200000; invert = 1'b1;
               tx_idle_pct <= 87; rx_stall_pct <= 0;
            end
            2: begin
               gain = GAIN_W'(-4096); offset = OFFSET_W'(1474560); invert = 1'b1;
               tx_idle_pct <= 0;  rx_stall_pct <= 87;
            end
            3: begin
               gain = '0; offset = OFFSET_W'(-1474560); invert = 1'b0;
               tx_idle_pct <= 26; rx_stall_pct <= 26;
            end
            4: begin
               gain = GAIN_W'($urandom); offset = OFFSET_W'($urandom); invert = 1'($urandom);
               tx_idle_pct <= 26; rx_stall_pct <= 26;
            end
            5: begin
               gain = GAIN_W'($urandom); offset = OFFSET_W'($urandom); invert = 1'($urandom);
               tx_idle_pct <= 0;  rx_stall_pct <= 0;  with_hold = 1'b1;
            end
            default: begin
               gain = GAIN_W'(1); offset = '0; invert = 1'b1;
               tx_idle_pct <= 87; rx_stall_pct <= 0;
            end
         endcase
         load_settings(gain, offset, invert);

         for (int unsigned item = 0; item < ITEMS_PER_PHASE; item++) begin
            // hold the receiver off while beats keep coming, so the block fills
            if (with_hold && (item == 30 || item == 130)) hold_req <= ~hold_req;
            cmd = ($urandom_range(99) < 6) ? CMD_REZERO : CMD_SAMPLE;
            // a quarter of the counts sit within two of the half turn
            if ($urandom_range(3) == 0)
               raw = zero_hint + RAW_W'(2046 + $urandom_range(4));
            else
               raw = RAW_W'($urandom);
            send_beat(cmd, raw);
         end
         drain();
      end

      repeat (20) @(posedge clock);
      if (fault_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
